// ===== rtl/ipv4lpm_pkg.sv =====
// Shared types and constants of the IPv4 trie longest-prefix-match core.
package ipv4lpm_pkg;

  localparam int ADDR_BITS = 32;
  localparam int DEPTH_W   = 6;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_DUP  = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic        cmd;
    logic [31:0] address;
    logic [5:0]  prefix_len;
    logic [31:0] gateway;
    logic [7:0]  iface;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] route_gateway;
    logic [7:0]  route_iface;
  } rsp_t;

endpackage

// ===== rtl/ipv4lpm_ram.sv =====
// Simple dual-port RAM with one write port and one registered read port.
module ipv4lpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ipv4_trie_longest_prefix_match_core.sv =====
// Top level: binary trie route table with bit-serial insert and lookup walks.
// An insert walks one trie level per prefix bit (ending early when the node store fills),
// a lookup at most one level per address bit, reading the node RAM for each level below the root.
// Once the walk ends, the result moves into the output register when that is free, and the
// next request is taken once the result has moved to the output register.
// Reset (synchronous, rst_n low) clears the root node and resets the free pointer;
// other nodes are cleared as they are allocated, so no clearing pass is needed.
module ipv4_trie_longest_prefix_match_core #(
  parameter int NODE_COUNT = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ipv4lpm_pkg::req_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ipv4lpm_pkg::rsp_t  out_data
);

  localparam int IDX_W  = $clog2(NODE_COUNT);
  localparam int NFW    = IDX_W + 1;
  localparam int NODE_W = 2 * IDX_W + 1;
  localparam int ROUTE_W = 40;
  localparam logic [NFW-1:0] NODE_LIMIT = NFW'(NODE_COUNT);
  localparam logic [ipv4lpm_pkg::DEPTH_W-1:0] MAX_DEPTH =
    ipv4lpm_pkg::DEPTH_W'(ipv4lpm_pkg::ADDR_BITS);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [ipv4lpm_pkg::ADDR_BITS-1:0] addr_r, addr_nxt;
  logic [ipv4lpm_pkg::DEPTH_W-1:0]   depth_r, depth_nxt;
  logic [ipv4lpm_pkg::DEPTH_W-1:0]   plen_r, plen_nxt;
  logic                              cmd_r, cmd_nxt;
  logic [31:0]                       hop_r, hop_nxt;
  logic [7:0]                        iface_r, iface_nxt;
  logic [IDX_W-1:0]                  node_r, node_nxt;
  logic                              fresh_r, fresh_nxt;
  logic [IDX_W-1:0]                  best_r, best_nxt;
  logic                              found_r, found_nxt;
  logic [1:0]                        status_r, status_nxt;
  logic [NFW-1:0]                    nfree_r, nfree_nxt;
  logic [IDX_W-1:0]                  root_c0_r, root_c0_nxt;
  logic [IDX_W-1:0]                  root_c1_r, root_c1_nxt;
  logic                              root_valid_r, root_valid_nxt;
  logic                              out_valid_r, out_valid_nxt;
  ipv4lpm_pkg::rsp_t                 out_data_r, out_data_nxt;

  // Node RAM and route RAM ports.
  logic              node_we, node_re;
  logic [IDX_W-1:0]  node_waddr, node_raddr;
  logic [NODE_W-1:0] node_wdata, node_rdata;
  logic              route_we, route_re;
  logic [IDX_W-1:0]  route_waddr, route_raddr;
  logic [ROUTE_W-1:0] route_wdata, route_rdata;

  // Current node record and walk decisions.
  logic [IDX_W-1:0] cur_c0, cur_c1, child;
  logic             cur_valid, bit_now, at_end;
  logic [IDX_W-1:0] wr_c0, wr_c1;
  logic             wr_valid, wr_en;
  logic             lk_found;
  logic [IDX_W-1:0] lk_best;

  ipv4lpm_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .re    (node_re),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  ipv4lpm_ram #(.WIDTH(ROUTE_W), .DEPTH(NODE_COUNT)) u_route_ram (
    .clk   (clk),
    .we    (route_we),
    .waddr (route_waddr),
    .wdata (route_wdata),
    .re    (route_re),
    .raddr (route_raddr),
    .rdata (route_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The root lives in flip-flops; a freshly allocated node is known to be empty.
  always_comb begin
    if (node_r == '0) begin
      cur_c0    = root_c0_r;
      cur_c1    = root_c1_r;
      cur_valid = root_valid_r;
    end else if (fresh_r) begin
      cur_c0    = '0;
      cur_c1    = '0;
      cur_valid = 1'b0;
    end else begin
      cur_c0    = node_rdata[NODE_W-1 -: IDX_W];
      cur_c1    = node_rdata[IDX_W:1];
      cur_valid = node_rdata[0];
    end
  end

  assign bit_now  = addr_r[ipv4lpm_pkg::ADDR_BITS-1];
  assign child    = bit_now ? cur_c1 : cur_c0;
  assign at_end   = (cmd_r == ipv4lpm_pkg::CMD_INSERT) ? (depth_r == plen_r)
                                                       : (depth_r == MAX_DEPTH);
  assign lk_found = found_r | cur_valid;
  assign lk_best  = cur_valid ? node_r : best_r;

  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    depth_nxt      = depth_r;
    plen_nxt       = plen_r;
    cmd_nxt        = cmd_r;
    hop_nxt        = hop_r;
    iface_nxt      = iface_r;
    node_nxt       = node_r;
    fresh_nxt      = fresh_r;
    best_nxt       = best_r;
    found_nxt      = found_r;
    status_nxt     = status_r;
    nfree_nxt      = nfree_r;
    root_c0_nxt    = root_c0_r;
    root_c1_nxt    = root_c1_r;
    root_valid_nxt = root_valid_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;

    wr_en    = 1'b0;
    wr_c0    = cur_c0;
    wr_c1    = cur_c1;
    wr_valid = cur_valid;

    node_re     = 1'b0;
    node_raddr  = child;
    route_we    = 1'b0;
    route_waddr = node_r;
    route_wdata = {hop_r, iface_r};
    route_re    = 1'b0;
    route_raddr = lk_best;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_data.cmd;
          addr_nxt  = in_data.address;
          plen_nxt  = (in_data.prefix_len > MAX_DEPTH) ? MAX_DEPTH : in_data.prefix_len;
          hop_nxt   = in_data.gateway;
          iface_nxt = in_data.iface;
          depth_nxt = '0;
          node_nxt  = '0;
          fresh_nxt = 1'b0;
          best_nxt  = '0;
          found_nxt = 1'b0;
          state_nxt = S_WALK;
        end
      end

      S_WALK: begin
        if (cmd_r == ipv4lpm_pkg::CMD_INSERT) begin
          // Every visited node is written back, so a fresh node is cleared here.
          wr_en = 1'b1;
          if (at_end) begin
            if (cur_valid) begin
              status_nxt = ipv4lpm_pkg::ST_DUP;
            end else begin
              status_nxt = ipv4lpm_pkg::ST_OK;
              wr_valid   = 1'b1;
              route_we   = 1'b1;
            end
            state_nxt = S_DONE;
          end else if (child == '0) begin
            if (nfree_r >= NODE_LIMIT) begin
              status_nxt = ipv4lpm_pkg::ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              if (bit_now) begin
                wr_c1 = nfree_r[IDX_W-1:0];
              end else begin
                wr_c0 = nfree_r[IDX_W-1:0];
              end
              node_nxt  = nfree_r[IDX_W-1:0];
              fresh_nxt = 1'b1;
              nfree_nxt = nfree_r + 1'b1;
              addr_nxt  = addr_r << 1;
              depth_nxt = depth_r + 1'b1;
            end
          end else begin
            node_re   = 1'b1;
            node_nxt  = child;
            fresh_nxt = 1'b0;
            addr_nxt  = addr_r << 1;
            depth_nxt = depth_r + 1'b1;
          end
        end else begin
          best_nxt  = lk_best;
          found_nxt = lk_found;
          if (at_end || child == '0) begin
            status_nxt = lk_found ? ipv4lpm_pkg::ST_OK : ipv4lpm_pkg::ST_MISS;
            route_re   = lk_found;
            state_nxt  = S_DONE;
          end else begin
            node_re   = 1'b1;
            node_nxt  = child;
            fresh_nxt = 1'b0;
            addr_nxt  = addr_r << 1;
            depth_nxt = depth_r + 1'b1;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.status = status_r;
          if (cmd_r == ipv4lpm_pkg::CMD_LOOKUP && status_r == ipv4lpm_pkg::ST_OK) begin
            out_data_nxt.route_gateway = route_rdata[ROUTE_W-1 -: 32];
            out_data_nxt.route_iface   = route_rdata[7:0];
          end else begin
            out_data_nxt.route_gateway = '0;
            out_data_nxt.route_iface   = '0;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (wr_en && node_r == '0) begin
      root_c0_nxt    = wr_c0;
      root_c1_nxt    = wr_c1;
      root_valid_nxt = wr_valid;
    end
  end

  assign node_we    = wr_en && (node_r != '0);
  assign node_waddr = node_r;
  assign node_wdata = {wr_c0, wr_c1, wr_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      nfree_r      <= NFW'(1);
      root_c0_r    <= '0;
      root_c1_r    <= '0;
      root_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      nfree_r      <= nfree_nxt;
      root_c0_r    <= root_c0_nxt;
      root_c1_r    <= root_c1_nxt;
      root_valid_r <= root_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    depth_r    <= depth_nxt;
    plen_r     <= plen_nxt;
    cmd_r      <= cmd_nxt;
    hop_r      <= hop_nxt;
    iface_r    <= iface_nxt;
    node_r     <= node_nxt;
    fresh_r    <= fresh_nxt;
    best_r     <= best_nxt;
    found_r    <= found_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  a_accept_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_WALK)
    else $error("accepted request did not start a walk");

  a_free_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    nfree_r <= NODE_LIMIT)
    else $error("free node pointer beyond node store");

  a_node_allocated: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> {1'b0, node_r} < nfree_r)
    else $error("walk visits an unallocated node");

  a_depth_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> depth_r <= MAX_DEPTH)
    else $error("walk depth beyond address width");

  a_done_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |-> !in_ready)
    else $error("request taken while a result is pending");

endmodule
